@@ design/rdq_pkg.sv @@
// Shared constants, codes, command/status structs and ring helpers for the ring deque.
package rdq_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 64;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = OCC_W + 1;

    // fixed port widths
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [OCC_W-1:0]      occ_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_FIND       = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic pop_load;
        logic scan_step;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic single;
        logic hit;
        logic last;
    } stat_t;

    // (base + off) mod DEPTH, off below twice DEPTH
    function automatic addr_t ring_add(input addr_t base, input occ_t off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic addr_t ring_dec(input addr_t base);
        addr_t res;
        if (base == '0)
        begin
            res = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            res = base - ADDR_W'(1);
        end
        return res;
    endfunction

endpackage

@@ design/ring_deque_with_search.sv @@
// Ring deque with search: top level joining the controller and the datapath.
//
// A bounded deque of up to 16 64-bit words held in a ring of RAM slots. A request
// pushes at the front, pushes at the back, pops from the front or searches for a
// word; every result carries the status, the popped word, the search outcome and
// the count and end words after the request. One request is in the block at a
// time. Pushes, error cases, a pop that empties the store and a search of an
// empty store go from execute to the result register; other pops refill the
// head cache first and a search scans from the front, one word compared per cycle
// through the single read port of the slot RAM. The next request is accepted in
// the cycle after the result has been loaded, even while that result still waits
// on out_stall; a result that cannot be loaded holds the block until the output
// register frees. Slot contents are not cleared at reset and need no clearing.
module ring_deque_with_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rdq_pkg::OP_W-1:0]      op,
    input  logic [rdq_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rdq_pkg::STATUS_W-1:0]  status,
    output logic [rdq_pkg::VALUE_W-1:0]   popped_value,
    output logic                          found,
    output logic [rdq_pkg::POS_W-1:0]     position,
    output logic [rdq_pkg::COUNT_W-1:0]   count,
    output logic [rdq_pkg::VALUE_W-1:0]   head_value,
    output logic [rdq_pkg::VALUE_W-1:0]   tail_value
);

    rdq_pkg::cmd_t  cmd;
    rdq_pkg::stat_t stat;

    rdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rdq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .value        (value),
        .status       (status),
        .popped_value (popped_value),
        .found        (found),
        .position     (position),
        .count        (count),
        .head_value   (head_value),
        .tail_value   (tail_value)
    );

endmodule

@@ design/rdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rdq_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/rdq_datapath.sv @@
// Datapath: slot RAM, front/occupancy registers, end-word caches, scan pointer and result register.
module rdq_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rdq_pkg::cmd_t                 cmd,
    output rdq_pkg::stat_t                stat,
    input  logic [rdq_pkg::OP_W-1:0]      op,
    input  logic [rdq_pkg::VALUE_W-1:0]   value,
    output logic [rdq_pkg::STATUS_W-1:0]  status,
    output logic [rdq_pkg::VALUE_W-1:0]   popped_value,
    output logic                          found,
    output logic [rdq_pkg::POS_W-1:0]     position,
    output logic [rdq_pkg::COUNT_W-1:0]   count,
    output logic [rdq_pkg::VALUE_W-1:0]   head_value,
    output logic [rdq_pkg::VALUE_W-1:0]   tail_value
);

    rdq_pkg::addr_t   front_reg, front_next;
    rdq_pkg::occ_t    occ_reg, occ_next;
    rdq_pkg::word_t   head_reg, head_next;
    rdq_pkg::word_t   tail_reg, tail_next;
    rdq_pkg::op_t     op_reg, op_next;
    rdq_pkg::word_t   val_reg, val_next;
    rdq_pkg::occ_t    scan_reg, scan_next;
    rdq_pkg::occ_t    cmp_pos_reg, cmp_pos_next;
    logic             pend_reg, pend_next;

    rdq_pkg::status_t st_reg, st_next;
    rdq_pkg::word_t   popped_reg, popped_next;
    logic             found_reg, found_next;
    rdq_pkg::occ_t    pos_reg, pos_next;

    logic [rdq_pkg::STATUS_W-1:0] status_out_reg, status_out_next;
    logic [rdq_pkg::VALUE_W-1:0]  popped_out_reg, popped_out_next;
    logic                         found_out_reg, found_out_next;
    logic [rdq_pkg::POS_W-1:0]    pos_out_reg, pos_out_next;
    logic [rdq_pkg::COUNT_W-1:0]  count_out_reg, count_out_next;
    logic [rdq_pkg::VALUE_W-1:0]  head_out_reg, head_out_next;
    logic [rdq_pkg::VALUE_W-1:0]  tail_out_reg, tail_out_next;

    logic           ram_we;
    rdq_pkg::addr_t ram_waddr;
    rdq_pkg::addr_t ram_raddr;
    rdq_pkg::word_t ram_rdata;

    logic           full;
    logic           empty;
    rdq_pkg::addr_t front_inc;
    rdq_pkg::addr_t front_dec;

    rdq_ram #(
        .WIDTH (rdq_pkg::WORD_WIDTH),
        .WORDS (rdq_pkg::DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full      = (occ_reg == rdq_pkg::OCC_W'(rdq_pkg::DEPTH));
    assign empty     = (occ_reg == '0);
    assign front_inc = rdq_pkg::ring_add(front_reg, rdq_pkg::OCC_W'(1));
    assign front_dec = rdq_pkg::ring_dec(front_reg);

    assign stat.op     = op_reg;
    assign stat.empty  = empty;
    assign stat.single = (occ_reg == rdq_pkg::OCC_W'(1));
    assign stat.hit    = pend_reg && (ram_rdata == val_reg);
    assign stat.last   = pend_reg && (cmp_pos_reg == occ_reg - rdq_pkg::OCC_W'(1));

    always_comb
    begin
        front_next   = front_reg;
        occ_next     = occ_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        scan_next    = scan_reg;
        cmp_pos_next = cmp_pos_reg;
        pend_next    = pend_reg;
        st_next      = st_reg;
        popped_next  = popped_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        ram_we       = 1'b0;
        ram_waddr    = front_reg;
        ram_raddr    = rdq_pkg::ring_add(front_reg, scan_reg);

        status_out_next = status_out_reg;
        popped_out_next = popped_out_reg;
        found_out_next  = found_out_reg;
        pos_out_next    = pos_out_reg;
        count_out_next  = count_out_reg;
        head_out_next   = head_out_reg;
        tail_out_next   = tail_out_reg;

        if (cmd.capture)
        begin
            op_next  = rdq_pkg::op_t'(op);
            val_next = value[rdq_pkg::WORD_WIDTH-1:0];
        end

        if (cmd.exec)
        begin
            st_next     = rdq_pkg::ST_OK;
            popped_next = '0;
            found_next  = 1'b0;
            pos_next    = '0;
            scan_next   = '0;
            pend_next   = 1'b0;
            unique case (op_reg)
                rdq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        st_next = rdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = front_dec;
                        front_next = front_dec;
                        occ_next   = occ_reg + rdq_pkg::OCC_W'(1);
                        head_next  = val_reg;
                        if (empty)
                        begin
                            tail_next = val_reg;
                        end
                    end
                end
                rdq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        st_next = rdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rdq_pkg::ring_add(front_reg, occ_reg);
                        occ_next  = occ_reg + rdq_pkg::OCC_W'(1);
                        tail_next = val_reg;
                        if (empty)
                        begin
                            head_next = val_reg;
                        end
                    end
                end
                rdq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        st_next = rdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        popped_next = head_reg;
                        front_next  = front_inc;
                        occ_next    = occ_reg - rdq_pkg::OCC_W'(1);
                        // fetch the new front word for the head cache
                        ram_raddr   = front_inc;
                    end
                end
                rdq_pkg::OP_FIND:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.pop_load)
        begin
            head_next = ram_rdata;
        end

        if (cmd.scan_step)
        begin
            if (stat.hit)
            begin
                found_next = 1'b1;
                pos_next   = cmp_pos_reg;
                pend_next  = 1'b0;
            end
            else if (scan_reg < occ_reg)
            begin
                pend_next    = 1'b1;
                cmp_pos_next = scan_reg;
                scan_next    = scan_reg + rdq_pkg::OCC_W'(1);
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        if (cmd.load_out)
        begin
            status_out_next = st_reg;
            popped_out_next = rdq_pkg::VALUE_W'(popped_reg);
            found_out_next  = found_reg;
            pos_out_next    = pos_reg[rdq_pkg::POS_W-1:0];
            count_out_next  = rdq_pkg::COUNT_W'(occ_reg);
            head_out_next   = empty ? '0 : rdq_pkg::VALUE_W'(head_reg);
            tail_out_next   = empty ? '0 : rdq_pkg::VALUE_W'(tail_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            occ_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        op_reg         <= op_next;
        val_reg        <= val_next;
        scan_reg       <= scan_next;
        cmp_pos_reg    <= cmp_pos_next;
        st_reg         <= st_next;
        popped_reg     <= popped_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        status_out_reg <= status_out_next;
        popped_out_reg <= popped_out_next;
        found_out_reg  <= found_out_next;
        pos_out_reg    <= pos_out_next;
        count_out_reg  <= count_out_next;
        head_out_reg   <= head_out_next;
        tail_out_reg   <= tail_out_next;
    end

    assign status       = status_out_reg;
    assign popped_value = popped_out_reg;
    assign found        = found_out_reg;
    assign position     = pos_out_reg;
    assign count        = count_out_reg;
    assign head_value   = head_out_reg;
    assign tail_value   = tail_out_reg;

endmodule

@@ design/rdq_ctrl.sv @@
// Controller: sequences one request through execute, pop refill, search scan and result load.
module rdq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  rdq_pkg::stat_t stat,
    output rdq_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.op == rdq_pkg::OP_FIND && !stat.empty)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.op == rdq_pkg::OP_POP_FRONT && !stat.empty && !stat.single)
                begin
                    state_next = S_POP_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_POP_RD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit || stat.last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ test/deque_result_checker.sv @@
// Checker for the ring deque: predicts each result from the accepted requests and compares.
`timescale 1ns / 1ps

module deque_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [rdq_pkg::OP_W-1:0]      op,
    input  logic [rdq_pkg::VALUE_W-1:0]   value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [rdq_pkg::STATUS_W-1:0]  status,
    input  logic [rdq_pkg::VALUE_W-1:0]   popped_value,
    input  logic                          found,
    input  logic [rdq_pkg::POS_W-1:0]     position,
    input  logic [rdq_pkg::COUNT_W-1:0]   count,
    input  logic [rdq_pkg::VALUE_W-1:0]   head_value,
    input  logic [rdq_pkg::VALUE_W-1:0]   tail_value,
    output int                            mismatches,
    output int                            results_awaited,
    output int                            results_checked
);

    typedef struct packed {
        rdq_pkg::status_t              status;
        rdq_pkg::word_t                popped;
        logic                          found;
        logic [rdq_pkg::POS_W-1:0]     position;
        logic [rdq_pkg::COUNT_W-1:0]   count;
        rdq_pkg::word_t                head;
        rdq_pkg::word_t                tail;
    } deque_result_t;

    rdq_pkg::word_t ring_words [rdq_pkg::DEPTH];
    rdq_pkg::addr_t front_slot;
    int             stored;
    deque_result_t  awaited_results [$];

    initial
    begin
        mismatches      = 0;
        results_awaited = 0;
        results_checked = 0;
    end

    function automatic rdq_pkg::addr_t slot_at(input int offset);
        return rdq_pkg::addr_t'((int'(front_slot) + offset) % rdq_pkg::DEPTH);
    endfunction

    // Applies one request to the shadow deque and returns the result it should give
    function automatic deque_result_t apply_request(input rdq_pkg::op_t req_op,
                                                    input rdq_pkg::word_t word);
        deque_result_t r;
        r.status   = rdq_pkg::ST_OK;
        r.popped   = '0;
        r.found    = 1'b0;
        r.position = '0;
        r.head     = '0;
        r.tail     = '0;
        case (req_op)
            rdq_pkg::OP_PUSH_FRONT,
            rdq_pkg::OP_PUSH_BACK:
            begin
                if (stored >= rdq_pkg::DEPTH)
                begin
                    r.status = rdq_pkg::ST_FULL;
                end
                else if (req_op == rdq_pkg::OP_PUSH_FRONT)
                begin
                    front_slot = rdq_pkg::addr_t'((int'(front_slot) + rdq_pkg::DEPTH - 1)
                                                  % rdq_pkg::DEPTH);
                    ring_words[front_slot] = word;
                    stored++;
                end
                else
                begin
                    ring_words[slot_at(stored)] = word;
                    stored++;
                end
            end
            rdq_pkg::OP_POP_FRONT:
            begin
                if (stored == 0)
                begin
                    r.status = rdq_pkg::ST_EMPTY;
                end
                else
                begin
                    r.popped   = ring_words[front_slot];
                    front_slot = slot_at(1);
                    stored--;
                end
            end
            default:
            begin
                // first match counted from the front
                for (int k = 0; k < stored; k++)
                begin
                    if (!r.found && ring_words[slot_at(k)] == word)
                    begin
                        r.found    = 1'b1;
                        r.position = rdq_pkg::POS_W'(k);
                    end
                end
            end
        endcase
        r.count = rdq_pkg::COUNT_W'(stored);
        if (stored != 0)
        begin
            r.head = ring_words[front_slot];
            r.tail = ring_words[slot_at(stored - 1)];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %h actual %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            front_slot = '0;
            stored     = 0;
            for (int i = 0; i < rdq_pkg::DEPTH; i++)
            begin
                ring_words[i] = '0;
            end
            awaited_results.delete();
            results_awaited = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result with none awaited, expected nothing actual status %h",
                             $realtime, status);
                end
                else
                begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    results_checked++;
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("popped_value", want.popped, popped_value);
                    check_field("found", 64'(want.found), 64'(found));
                    check_field("position", 64'(want.position), 64'(position));
                    check_field("count", 64'(want.count), 64'(count));
                    check_field("head_value", want.head, head_value);
                    check_field("tail_value", want.tail, tail_value);
                end
            end
            if (in_valid && !in_stall)
            begin
                awaited_results.insert(awaited_results.size(),
                                       apply_request(rdq_pkg::op_t'(op), value));
            end
            results_awaited = awaited_results.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the ring deque: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_REQUESTS = 1500;
    localparam int QUIET_TAIL      = 200;
    localparam int CYCLE_LIMIT     = 1000000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [rdq_pkg::OP_W-1:0]      op;
    logic [rdq_pkg::VALUE_W-1:0]   value;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [rdq_pkg::STATUS_W-1:0]  status;
    logic [rdq_pkg::VALUE_W-1:0]   popped_value;
    logic                          found;
    logic [rdq_pkg::POS_W-1:0]     position;
    logic [rdq_pkg::COUNT_W-1:0]   count;
    logic [rdq_pkg::VALUE_W-1:0]   head_value;
    logic [rdq_pkg::VALUE_W-1:0]   tail_value;

    int             mismatches;
    int             results_awaited;
    int             results_checked;
    int             cycles = 0;
    int             stall_left = 0;
    logic           stalls_on = 1'b0;
    logic           gaps_on = 1'b0;
    int             sent_by_op [4];
    rdq_pkg::word_t recent_pushes [16];
    int             recent_fill = 0;

    ring_deque_with_search i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .popped_value (popped_value),
        .found        (found),
        .position     (position),
        .count        (count),
        .head_value   (head_value),
        .tail_value   (tail_value)
    );

    deque_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .popped_value    (popped_value),
        .found           (found),
        .position        (position),
        .count           (count),
        .head_value      (head_value),
        .tail_value      (tail_value),
        .mismatches      (mismatches),
        .results_awaited (results_awaited),
        .results_checked (results_checked)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result-side back-pressure in bursts, started at random while stalls are on
    always @(posedge clk)
    begin
        if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 19);
            out_stall  <= 1'b1;
        end
    end

    function automatic rdq_pkg::word_t random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            return rdq_pkg::word_t'($urandom_range(0, 7));   // small range gives duplicates
        end
        else if (pick == 2)
        begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return {$urandom, $urandom};
    endfunction

    // Drives one request and returns at the edge that accepts it
    task automatic send(input rdq_pkg::op_t req_op, input rdq_pkg::word_t word);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= req_op;
        value    <= word;
        do
        begin
            @(negedge clk);
        end
        while (in_stall);
        @(posedge clk);
        sent_by_op[req_op]++;
        if (req_op == rdq_pkg::OP_PUSH_FRONT || req_op == rdq_pkg::OP_PUSH_BACK)
        begin
            recent_pushes[recent_fill % 16] = word;
            recent_fill++;
        end
    endtask

    initial
    begin
        int             bias;
        int             phase_left;
        int             roll;
        rdq_pkg::op_t   req_op;
        rdq_pkg::word_t word;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        op       <= rdq_pkg::OP_PUSH_FRONT;
        value    <= '0;
        for (int i = 0; i < 4; i++)
        begin
            sent_by_op[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, both ends, full store, search at the far end
        send(rdq_pkg::OP_POP_FRONT, '1);
        send(rdq_pkg::OP_FIND, '0);
        send(rdq_pkg::OP_PUSH_BACK, '0);
        send(rdq_pkg::OP_PUSH_FRONT, '1);
        send(rdq_pkg::OP_FIND, '1);
        send(rdq_pkg::OP_FIND, '0);
        send(rdq_pkg::OP_FIND, 64'h5555_5555_5555_5555);
        for (int i = 0; i < 13; i++)
        begin
            word = (i % 2 == 0) ? 64'hAAAA_AAAA_AAAA_AAAA : 64'h5555_5555_5555_5555;
            req_op = rdq_pkg::op_t'((i % 3 == 0) ? rdq_pkg::OP_PUSH_FRONT
                                                 : rdq_pkg::OP_PUSH_BACK);
            send(req_op, word ^ rdq_pkg::word_t'(i));
        end
        send(rdq_pkg::OP_PUSH_BACK, 64'h8000_0000_0000_0001);
        send(rdq_pkg::OP_PUSH_FRONT, 64'h0123_4567_89AB_CDEF);
        send(rdq_pkg::OP_PUSH_BACK, 64'h0123_4567_89AB_CDEF);
        send(rdq_pkg::OP_FIND, 64'h8000_0000_0000_0001);
        send(rdq_pkg::OP_POP_FRONT, '0);

        // random: phases that lean towards filling, draining or searching
        bias       = 0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(60, 150);
                bias       = $urandom_range(0, 3);
                stalls_on  = ($urandom_range(0, 3) != 0);
                gaps_on    = ($urandom_range(0, 3) != 0);
            end
            phase_left--;
            if (n >= RANDOM_REQUESTS - QUIET_TAIL)
            begin
                stalls_on = 1'b0;
                gaps_on   = 1'b0;
            end
            roll = $urandom_range(0, 99);
            case (bias)
                0:       req_op = rdq_pkg::op_t'((roll < 35) ? rdq_pkg::OP_PUSH_FRONT :
                                  (roll < 70) ? rdq_pkg::OP_PUSH_BACK :
                                  (roll < 85) ? rdq_pkg::OP_POP_FRONT : rdq_pkg::OP_FIND);
                1:       req_op = rdq_pkg::op_t'((roll < 10) ? rdq_pkg::OP_PUSH_FRONT :
                                  (roll < 20) ? rdq_pkg::OP_PUSH_BACK :
                                  (roll < 75) ? rdq_pkg::OP_POP_FRONT : rdq_pkg::OP_FIND);
                2:       req_op = rdq_pkg::op_t'((roll < 20) ? rdq_pkg::OP_PUSH_FRONT :
                                  (roll < 40) ? rdq_pkg::OP_PUSH_BACK :
                                  (roll < 60) ? rdq_pkg::OP_POP_FRONT : rdq_pkg::OP_FIND);
                default: req_op = rdq_pkg::op_t'((roll < 25) ? rdq_pkg::OP_PUSH_FRONT :
                                  (roll < 50) ? rdq_pkg::OP_PUSH_BACK :
                                  (roll < 75) ? rdq_pkg::OP_POP_FRONT : rdq_pkg::OP_FIND);
            endcase
            word = random_word();
            // reuse earlier pushed words so searches hit and duplicates occur
            if (recent_fill != 0 &&
                $urandom_range(0, 9) < ((req_op == rdq_pkg::OP_FIND) ? 6 : 2))
            begin
                word = recent_pushes[$urandom_range(0, (recent_fill < 16 ? recent_fill : 16) - 1)];
            end
            send(req_op, word);
        end
        in_valid <= 1'b0;

        while (results_awaited != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Requests: %0d push front, %0d push back, %0d pop front, %0d find",
                 sent_by_op[rdq_pkg::OP_PUSH_FRONT], sent_by_op[rdq_pkg::OP_PUSH_BACK],
                 sent_by_op[rdq_pkg::OP_POP_FRONT], sent_by_op[rdq_pkg::OP_FIND]);
        $display("Results compared field by field: %0d", results_checked);
        if (mismatches == 0 && results_awaited == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
